FILE: src/pibba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibba_pkg
// Shared constants, codes and types of the process image bit/byte access
// block.
// ----------------------------------------------------------------------------
package pibba_pkg;

   // Geometry
   localparam int AREA_BYTES  = 1024;
   localparam int NUM_AREAS   = 3;
   localparam int NUM_LANES   = 4;    // byte lanes, one dword wide
   localparam int LANE_W      = 2;
   localparam int ROW_DEPTH   = (AREA_BYTES + NUM_LANES - 1) / NUM_LANES;
   localparam int ROW_W       = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
   localparam int ADDR_SUM_W  = 17;   // 16-bit address plus access width
   localparam logic [ADDR_SUM_W-1:0] AREA_LIMIT = ADDR_SUM_W'(AREA_BYTES);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      OP_RDBIT    = 4'd0,
      OP_RDBYTE   = 4'd1,
      OP_RDWORD   = 4'd2,
      OP_RDDWORD  = 4'd3,
      OP_SETBIT   = 4'd4,
      OP_RESETBIT = 4'd5,
      OP_INVBIT   = 4'd6,
      OP_WRBYTE   = 4'd7,
      OP_WRWORD   = 4'd8,
      OP_WRDWORD  = 4'd9,
      OP_CLEAR    = 4'd10
   } opcode_type;

   typedef enum logic [1:0] {
      ERR_OK   = 2'd0,
      ERR_BIT  = 2'd1,
      ERR_AREA = 2'd2,
      ERR_ADDR = 2'd3
   } err_code_type;

   // What the back end has to do with a request
   typedef enum logic [2:0] {
      K_RESP   = 3'd0,   // answer at once: failed check or unused opcode
      K_READ   = 3'd1,
      K_RDBIT  = 3'd2,
      K_SETBIT = 3'd3,
      K_RSTBIT = 3'd4,
      K_INVBIT = 3'd5,
      K_WRITE  = 3'd6,
      K_CLEAR  = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      BK_INIT,
      BK_IDLE,
      BK_RDATA,
      BK_CLEAR
   } back_state_type;

   typedef struct packed {
      kind_type                            kind;
      err_code_type                        err;
      logic [1:0]                          area_sel;   // 0 input, 1 output, 2 memory
      logic [LANE_W-1:0]                   shift;      // lane of the first byte
      logic [2:0]                          bit_idx;
      logic [NUM_LANES-1:0]                lane_en;    // lanes touched by the access
      logic [NUM_LANES-1:0]                byte_mask;  // result bytes in use
      logic [NUM_LANES-1:0][ROW_W-1:0]     lane_row;
      logic [NUM_LANES-1:0][7:0]           wr_byte;
      logic [NUM_AREAS-1:0]                clr_mask;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage

FILE: src/pibba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pibba_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pibba_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibba_front
// Request intake: range checks and decode into a lane-level command.
// ----------------------------------------------------------------------------
module pibba_front (
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [3:0]                 req_opcode,
   input  logic [1:0]                 req_area,
   input  logic [15:0]                req_byte_address,
   input  logic [3:0]                 req_bit_index,
   input  logic [31:0]                req_write_value,
   input  logic [2:0]                 req_clear_mask,
   input  pibba_pkg::back_status_type status,
   input  logic                       queue_full,
   output logic                       push,
   output pibba_pkg::cmd_type         push_cmd
);
   import pibba_pkg::*;

   logic [2:0]            width;
   logic [ADDR_SUM_W-1:0] end_sum;
   logic [ADDR_SUM_W-1:0] row_sum;
   logic [LANE_W-1:0]     k;

   assign req_stall = queue_full | status.init_busy;
   assign push      = req_valid & ~req_stall;

   always_comb begin
      case (req_opcode)
         OP_RDWORD, OP_WRWORD:   width = 3'd2;
         OP_RDDWORD, OP_WRDWORD: width = 3'd4;
         default:                width = 3'd1;
      endcase

      end_sum = {1'b0, req_byte_address} + ADDR_SUM_W'(width);
      row_sum = '0;
      k       = '0;

      push_cmd          = '0;
      push_cmd.kind     = K_RESP;
      push_cmd.err      = ERR_OK;
      push_cmd.area_sel = req_area - 2'd1;
      push_cmd.shift    = req_byte_address[LANE_W-1:0];
      push_cmd.bit_idx  = req_bit_index[2:0];
      push_cmd.clr_mask = req_clear_mask;

      // Lane l carries byte k of the access, k = l - first lane
      for (int l = 0; l < NUM_LANES; l++) begin
         k       = LANE_W'(l) - req_byte_address[LANE_W-1:0];
         row_sum = {1'b0, req_byte_address} + ADDR_SUM_W'(k);
         push_cmd.lane_row[l]  = row_sum[ROW_W+LANE_W-1:LANE_W];
         push_cmd.lane_en[l]   = ({1'b0, k} < width);
         push_cmd.wr_byte[l]   = req_write_value[{k, 3'b000} +: 8];
         push_cmd.byte_mask[l] = (3'(l) < width);
      end

      if (req_opcode == OP_CLEAR) begin
         push_cmd.kind = K_CLEAR;
      end else if (req_opcode > OP_WRDWORD) begin
         push_cmd.kind = K_RESP;
      end else if (req_bit_index > 4'd7) begin
         push_cmd.err = ERR_BIT;
      end else if (req_area == 2'd0) begin
         push_cmd.err = ERR_AREA;
      end else if (end_sum > AREA_LIMIT) begin
         push_cmd.err = ERR_ADDR;
      end else begin
         case (req_opcode)
            OP_RDBIT:                          push_cmd.kind = K_RDBIT;
            OP_RDBYTE, OP_RDWORD, OP_RDDWORD:  push_cmd.kind = K_READ;
            OP_SETBIT:                         push_cmd.kind = K_SETBIT;
            OP_RESETBIT:                       push_cmd.kind = K_RSTBIT;
            OP_INVBIT:                         push_cmd.kind = K_INVBIT;
            OP_WRBYTE, OP_WRWORD, OP_WRDWORD:  push_cmd.kind = K_WRITE;
            default:                           push_cmd.kind = K_RESP;
         endcase
      end
   end

endmodule

FILE: src/pibba_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibba_queue
// Short command FIFO between front and back.
// ----------------------------------------------------------------------------
module pibba_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pibba_pkg::cmd_type push_cmd,
   input  logic               pop,
   output logic               head_valid,
   output pibba_pkg::cmd_type head_cmd,
   output logic               full
);
   import pibba_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

FILE: src/pibba_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibba_back
// Execution: RAM reads and writes, bit read-modify-write, clear sweeps and
// the response register.
// ----------------------------------------------------------------------------
module pibba_back (
   input  logic                                                      clock,
   input  logic                                                      reset,
   input  logic                                                      head_valid,
   input  pibba_pkg::cmd_type                                        head_cmd,
   output logic                                                      pop,
   output pibba_pkg::back_status_type                                status,
   output logic [pibba_pkg::NUM_AREAS-1:0][pibba_pkg::NUM_LANES-1:0] wr_en,
   output logic [pibba_pkg::NUM_LANES-1:0][pibba_pkg::ROW_W-1:0]     wr_row,
   output logic [pibba_pkg::NUM_LANES-1:0][7:0]                      wr_byte,
   output logic [pibba_pkg::NUM_LANES-1:0][pibba_pkg::ROW_W-1:0]     rd_row,
   input  logic [pibba_pkg::NUM_AREAS-1:0][pibba_pkg::NUM_LANES-1:0][7:0] rd_data,
   output logic                                                      rsp_valid,
   input  logic                                                      rsp_stall,
   output logic [31:0]                                               rsp_read_value,
   output logic [1:0]                                                rsp_error_code
);
   import pibba_pkg::*;

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [NUM_AREAS-1:0] clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_value_ff;
   err_code_type         rsp_err_ff;

   logic                       rsp_free;
   logic                       rsp_load;
   logic [31:0]                rsp_value;
   err_code_type               rsp_err;
   logic [NUM_LANES-1:0][7:0]  sel_byte;
   logic [31:0]                rd_value;
   logic [7:0]                 old_byte;
   logic [7:0]                 bit_mask;
   logic [7:0]                 new_byte;
   logic                       sweep_last;

   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;
   assign sweep_last = (row_ff == ROW_W'(ROW_DEPTH - 1));
   assign rd_row     = head_cmd.lane_row;

   // Read data of the latched command's area, realigned to byte order
   always_comb begin
      sel_byte = rd_data[cmd_ff.area_sel];
      rd_value = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         rd_value[8*k +: 8] = cmd_ff.byte_mask[k]
                              ? sel_byte[LANE_W'(cmd_ff.shift + LANE_W'(k))] : 8'h00;
      end
      old_byte = sel_byte[cmd_ff.shift];
      bit_mask = 8'h01 << cmd_ff.bit_idx;
      case (cmd_ff.kind)
         K_SETBIT: new_byte = old_byte | bit_mask;
         K_RSTBIT: new_byte = old_byte & ~bit_mask;
         default:  new_byte = old_byte ^ bit_mask;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      row_in    = row_ff;
      clr_in    = clr_ff;
      pop       = 1'b0;
      rsp_load  = 1'b0;
      rsp_value = '0;
      rsp_err   = ERR_OK;
      wr_en     = '0;
      wr_row    = head_cmd.lane_row;
      wr_byte   = head_cmd.wr_byte;

      case (state_ff)
         BK_INIT, BK_CLEAR: begin
            for (int a = 0; a < NUM_AREAS; a++) begin
               wr_en[a] = {NUM_LANES{clr_ff[a]}};
            end
            for (int l = 0; l < NUM_LANES; l++) begin
               wr_row[l]  = row_ff;
               wr_byte[l] = 8'h00;
            end
            row_in = row_ff + 1'b1;
            if (sweep_last) begin
               row_in   = '0;
               state_in = BK_IDLE;
               rsp_load = (state_ff == BK_CLEAR);
            end
         end

         BK_IDLE: begin
            if (head_valid && rsp_free) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               case (head_cmd.kind)
                  K_WRITE: begin
                     wr_en[head_cmd.area_sel] = head_cmd.lane_en;
                     rsp_load = 1'b1;
                  end
                  K_READ, K_RDBIT, K_SETBIT, K_RSTBIT, K_INVBIT: begin
                     state_in = BK_RDATA;
                  end
                  K_CLEAR: begin
                     clr_in   = head_cmd.clr_mask;
                     row_in   = '0;
                     state_in = BK_CLEAR;
                  end
                  default: begin
                     rsp_load = 1'b1;
                     rsp_err  = head_cmd.err;
                  end
               endcase
            end
         end

         BK_RDATA: begin
            rsp_load = 1'b1;
            state_in = BK_IDLE;
            wr_row   = cmd_ff.lane_row;
            for (int l = 0; l < NUM_LANES; l++) begin
               wr_byte[l] = new_byte;
            end
            case (cmd_ff.kind)
               K_READ:  rsp_value = rd_value;
               K_RDBIT: rsp_value = {31'd0, old_byte[cmd_ff.bit_idx]};
               default: wr_en[cmd_ff.area_sel] = cmd_ff.lane_en;
            endcase
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         row_ff       <= '0;
         clr_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (rsp_load) begin
         rsp_value_ff <= rsp_value;
         rsp_err_ff   <= rsp_err;
      end
   end

   assign status.init_busy = (state_ff == BK_INIT);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_error_code   = rsp_err_ff;

endmodule

FILE: src/process_image_bit_byte_access.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_image_bit_byte_access
// Process image with input, output and memory byte areas; bit, byte,
// little-endian word and dword access, bit set/reset/invert and area clear.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_*     in         req_valid/req_stall  opcode, area, byte_address,
//                                             bit_index, write_value, clear_mask
//   rsp_*     out        rsp_valid/rsp_stall  read_value, error_code
//
// Flow: the front takes one request per cycle, while req_stall is low, into a
//   2-entry command queue. The back completes a write, a failed check or an
//   unused opcode straight from idle; a read or a bit set/reset/invert makes
//   one registered RAM read, then realigns or writes back; a clear sweeps one
//   row of every selected area per cycle. The back waits for each read to
//   finish before it takes the next command.
// Reset: synchronous; afterwards a pass over all ROW_DEPTH rows zeroes all
//   three areas, with req_stall held high for its length.
// Stalls: req_stall rises when the queue is full or the post-reset pass runs;
//   a result waits in the response register under rsp_stall while further requests queue up.
//
module process_image_bit_byte_access (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_opcode,
   input  logic [1:0]  req_area,
   input  logic [15:0] req_byte_address,
   input  logic [3:0]  req_bit_index,
   input  logic [31:0] req_write_value,
   input  logic [2:0]  req_clear_mask,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_value,
   output logic [1:0]  rsp_error_code
);
   import pibba_pkg::*;

   // front -> queue
   logic            push;
   cmd_type         push_cmd;
   logic            queue_full;
   // queue -> back
   logic            head_valid;
   cmd_type         head_cmd;
   logic            pop;
   back_status_type status;

   // RAM array: one bank per area and byte lane, one row = one dword
   logic [NUM_AREAS-1:0][NUM_LANES-1:0]      wr_en;
   logic [NUM_LANES-1:0][ROW_W-1:0]          wr_row;
   logic [NUM_LANES-1:0][7:0]                wr_byte;
   logic [NUM_LANES-1:0][ROW_W-1:0]          rd_row;
   logic [NUM_AREAS-1:0][NUM_LANES-1:0][7:0] rd_data;

   // Decode and range checks
   pibba_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_area         (req_area),
      .req_byte_address (req_byte_address),
      .req_bit_index    (req_bit_index),
      .req_write_value  (req_write_value),
      .req_clear_mask   (req_clear_mask),
      .status           (status),
      .queue_full       (queue_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   pibba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (queue_full)
   );

   // Execution and response register
   pibba_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .status         (status),
      .wr_en          (wr_en),
      .wr_row         (wr_row),
      .wr_byte        (wr_byte),
      .rd_row         (rd_row),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_error_code (rsp_error_code)
   );

   // Lanes are addressed separately so an unaligned dword still reads and
   // writes in one access.
   for (genvar a = 0; a < NUM_AREAS; a++) begin : g_area
      for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
         pibba_ram #(
            .WIDTH (8),
            .DEPTH (ROW_DEPTH)
         ) u_ram (
            .clock   (clock),
            .wr_en   (wr_en[a][l]),
            .wr_addr (wr_row[l]),
            .wr_data (wr_byte[l]),
            .rd_addr (rd_row[l]),
            .rd_data (rd_data[a][l])
         );
      end
   end

endmodule

FILE: src/pibba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibba_checker
// Port-level assertions for the process image block, bound to the top.
// ----------------------------------------------------------------------------
module pibba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [3:0]  req_opcode,
   input logic [1:0]  req_area,
   input logic [15:0] req_byte_address,
   input logic [3:0]  req_bit_index,
   input logic [31:0] req_write_value,
   input logic [2:0]  req_clear_mask,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_read_value,
   input logic [1:0]  rsp_error_code
);
   import pibba_pkg::*;

   // The clearing pass holds off requests right after reset
   a_init_stall : assert property (@(posedge clock) reset |=> req_stall)
      else $error("request accepted during post-reset clear");

   a_no_rsp_after_reset : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response out of reset");

   a_err_zero_value : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_OK |-> rsp_read_value == 32'd0)
      else $error("failed request returned data");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
                                 && $stable(rsp_error_code))
      else $error("stalled response changed");

   // A stalled request stays put until it is taken
   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_opcode)
                                 && $stable(req_area) && $stable(req_byte_address)
                                 && $stable(req_bit_index) && $stable(req_write_value)
                                 && $stable(req_clear_mask))
      else $error("stalled request changed");

endmodule

bind process_image_bit_byte_access pibba_checker u_checker (.*);
